/* rtl/shared_double_ended_stack_unit_defines.svh */
// ----------------------------------------------------------------------------
// Shared double-ended stack: assertion macros
// Concurrent check helpers used by the top level of the stack unit.
// ----------------------------------------------------------------------------
`ifndef SHARED_DOUBLE_ENDED_STACK_UNIT_DEFINES_SVH
`define SHARED_DOUBLE_ENDED_STACK_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SDES_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sdes: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SDES_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sdes: next-cycle check failed");

`endif

/* rtl/sdes_pkg.sv */
// ----------------------------------------------------------------------------
// Shared double-ended stack package
// Codes, widths and the memory command bundle shared by the stack unit.
// ----------------------------------------------------------------------------
package sdes_pkg;

   localparam int WORD_W   = 32;
   localparam int STATUS_W = 2;

   // request kind
   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_POP  = 1'b1;

   // stack select
   localparam logic SEL_LOWER = 1'b0;
   localparam logic SEL_UPPER = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_cmd_type;

endpackage

/* rtl/shared_double_ended_stack_unit.sv */
// ----------------------------------------------------------------------------
// Shared double-ended stack unit
// Two LIFO stacks in one RAM: lower grows up from 0, upper down from DEPTH-1.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_type (0 push, 1 pop), req_stack_sel (0 lower,
//   1 upper) and req_push_value with start high; the beat is taken at the
//   rising edge where start is high and busy is low. busy stays low: the
//   unit takes one request every cycle.
//   Result channel: exactly one result beat per request, shown for one cycle
//   with rsp_strobe high, in the cycle right after the request edge.
//   rsp_status is 0 done, 1 full (push refused), 2 empty (pop refused);
//   rsp_pop_value carries the popped word, zero otherwise.
//   Throughput 1 request per cycle, registered result beat. Both come from
//   the single-port RAM: a push writes at the request edge, a pop reads at
//   the request edge and the registered read data is the result word.
//   Fill counters update at the request edge, so a pop right after a push
//   to the same stack reads the word already written; no forwarding needed.
//   Reset (synchronous, active high) empties both stacks and drops any
//   pending result beat; RAM contents are not cleared.
//   The receiver cannot stall: a result beat is lost if not taken.
// ----------------------------------------------------------------------------
`include "shared_double_ended_stack_unit_defines.svh"

module shared_double_ended_stack_unit #(
   parameter int DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_type,
   input  logic                                req_stack_sel,
   input  logic signed [sdes_pkg::WORD_W-1:0]  req_push_value,
   output logic                                rsp_strobe,
   output logic [sdes_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [sdes_pkg::WORD_W-1:0]  rsp_pop_value
);

   // RAM address width and fill-counter width (counter must hold DEPTH)
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic                         accept;
   sdes_pkg::mem_cmd_type        mem_cmd;
   logic [AW-1:0]                mem_addr;
   logic [sdes_pkg::WORD_W-1:0]  rd_data;
   logic                         rsp_valid;
   sdes_pkg::status_type         rsp_code;
   logic                         pop_ok;

   // never stalls: every request is accepted when start is high
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   sdes_ctrl #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .CW    (CW)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .req_type      (req_type),
      .req_stack_sel (req_stack_sel),
      .mem_cmd       (mem_cmd),
      .mem_addr      (mem_addr),
      .rsp_valid     (rsp_valid),
      .rsp_code      (rsp_code),
      .pop_ok        (pop_ok)
   );

   sdes_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .cmd     (mem_cmd),
      .addr    (mem_addr),
      .wr_data (req_push_value),
      .rd_data (rd_data)
   );

   // read data is only meaningful after a successful pop; zero otherwise
   assign rsp_strobe    = rsp_valid;
   assign rsp_status    = rsp_code;
   assign rsp_pop_value = pop_ok ? $signed(rd_data) : '0;

   // one result beat for every request beat, and none without
   `SDES_ASSERT_NEXT(a_rsp_follows_req, clock, reset, accept, rsp_strobe)
   `SDES_ASSERT_NEXT(a_no_rsp_unasked, clock, reset, !accept, !rsp_strobe)
   // single-port RAM: never read and write in one cycle
   `SDES_ASSERT_NOW(a_mem_one_port, clock, reset, 1'b1, !(mem_cmd.wr_en && mem_cmd.rd_en))
   // a full refusal can only answer a push
   `SDES_ASSERT_NEXT(a_full_on_push, clock, reset, accept && req_type == sdes_pkg::REQ_POP, rsp_status != sdes_pkg::STATUS_FULL)

endmodule

/* rtl/sdes_mem.sv */
// ----------------------------------------------------------------------------
// Stack word memory
// Single-port synchronous RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module sdes_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                         clock,
   input  sdes_pkg::mem_cmd_type        cmd,
   input  logic [AW-1:0]                addr,
   input  logic [sdes_pkg::WORD_W-1:0]  wr_data,
   output logic [sdes_pkg::WORD_W-1:0]  rd_data
);

   logic [sdes_pkg::WORD_W-1:0] mem_ff [DEPTH];
   logic [sdes_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/sdes_ctrl.sv */
// ----------------------------------------------------------------------------
// Stack pointer control
// Tracks both stack fills, decides full/empty and drives the memory access.
// ----------------------------------------------------------------------------
module sdes_ctrl #(
   parameter int DEPTH = 64,
   parameter int AW    = 6,
   parameter int CW    = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic                  req_type,
   input  logic                  req_stack_sel,
   output sdes_pkg::mem_cmd_type mem_cmd,
   output logic [AW-1:0]         mem_addr,
   output logic                  rsp_valid,
   output sdes_pkg::status_type  rsp_code,
   output logic                  pop_ok
);

   localparam logic [AW-1:0] TOP_ADDR = AW'(DEPTH - 1);
   localparam logic [CW:0]   FULL_CNT = (CW + 1)'(DEPTH);

   logic [CW-1:0]        lower_ff, lower_in;
   logic [CW-1:0]        upper_ff, upper_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   sdes_pkg::status_type code_ff, code_in;
   logic                 pop_ok_ff, pop_ok_in;
   logic [CW:0]          total;
   logic                 full;
   logic [CW-1:0]        lower_dec;
   logic [CW-1:0]        upper_dec;

   assign total     = {1'b0, lower_ff} + {1'b0, upper_ff};
   assign full      = (total >= FULL_CNT);
   assign lower_dec = lower_ff - 1'b1;
   assign upper_dec = upper_ff - 1'b1;

   always_comb begin
      lower_in     = lower_ff;
      upper_in     = upper_ff;
      rsp_valid_in = accept;
      code_in      = sdes_pkg::STATUS_DONE;
      pop_ok_in    = 1'b0;
      mem_cmd      = '0;
      mem_addr     = '0;
      if (accept) begin
         if (req_type == sdes_pkg::REQ_PUSH) begin
            if (full) begin
               code_in = sdes_pkg::STATUS_FULL;
            end else if (req_stack_sel == sdes_pkg::SEL_LOWER) begin
               mem_cmd.wr_en = 1'b1;
               mem_addr      = lower_ff[AW-1:0];
               lower_in      = lower_ff + 1'b1;
            end else begin
               mem_cmd.wr_en = 1'b1;
               mem_addr      = TOP_ADDR - upper_ff[AW-1:0];
               upper_in      = upper_ff + 1'b1;
            end
         end else begin
            if (req_stack_sel == sdes_pkg::SEL_LOWER) begin
               if (lower_ff == '0) begin
                  code_in = sdes_pkg::STATUS_EMPTY;
               end else begin
                  mem_cmd.rd_en = 1'b1;
                  mem_addr      = lower_dec[AW-1:0];
                  lower_in      = lower_dec;
                  pop_ok_in     = 1'b1;
               end
            end else begin
               if (upper_ff == '0) begin
                  code_in = sdes_pkg::STATUS_EMPTY;
               end else begin
                  mem_cmd.rd_en = 1'b1;
                  mem_addr      = TOP_ADDR - upper_dec[AW-1:0];
                  upper_in      = upper_dec;
                  pop_ok_in     = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff     <= '0;
         upper_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         lower_ff     <= lower_in;
         upper_ff     <= upper_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      code_ff   <= code_in;
      pop_ok_ff <= pop_ok_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_code  = code_ff;
   assign pop_ok    = pop_ok_ff;

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Shared double-ended stack unit: regression bench
// Drives push/pop beats on both stacks, predicts each result beat with a
// behavioral model of the two shared-memory stacks, and checks every beat.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import sdes_pkg::*;

   localparam int DEPTH          = 64;
   localparam int RANDOM_BEATS   = 430;
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on either side
   localparam int DRAIN_CYCLES   = 4;     // result beat is registered, keep some margin

   // ---------------------------------------------------------------------------
   // Types
   // ---------------------------------------------------------------------------
   typedef struct packed {
      status_type          status;
      logic [WORD_W-1:0]   word;
   } stack_result_t;

   // typed-in expectation carried alongside a directed beat
   typedef struct packed {
      logic                fixed;
      status_type          status;
      logic [WORD_W-1:0]   pop_word;
   } typed_result_t;

   typedef struct packed {
      logic                kind;
      logic                sel;
      logic [WORD_W-1:0]   push_word;
      logic                fixed;
      status_type          status;
      logic [WORD_W-1:0]   pop_word;
   } directed_beat_t;

   // ---------------------------------------------------------------------------
   // DUT signals: every input known from time zero
   // ---------------------------------------------------------------------------
   logic                       clock;
   logic                       reset          = 1'b1;
   logic                       start          = 1'b0;
   logic                       busy;
   logic                       req_type       = REQ_PUSH;
   logic                       req_stack_sel  = SEL_LOWER;
   logic signed [WORD_W-1:0]   req_push_value = '0;
   logic                       rsp_strobe;
   logic [STATUS_W-1:0]        rsp_status;
   logic signed [WORD_W-1:0]   rsp_pop_value;

   shared_double_ended_stack_unit #(
      .DEPTH(DEPTH)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_stack_sel  (req_stack_sel),
      .req_push_value (req_push_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_pop_value  (rsp_pop_value)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Stack model: shared word store plus the two fill levels.
   // Lower top sits at stack_words[lower_fill-1], upper top at
   // stack_words[DEPTH-upper_fill].
   // ---------------------------------------------------------------------------
   logic [WORD_W-1:0]  stack_words [DEPTH];
   int unsigned        lower_fill = 0;
   int unsigned        upper_fill = 0;

   stack_result_t      pending_results [$];  // predicted beats not yet seen
   typed_result_t      typed_results   [$];  // one per driven beat, in order
   int                 error_count = 0;
   int                 beats_sent  = 0;

   // driver's own view of the fill levels, used only to steer the stimulus
   int unsigned        plan_lower = 0;
   int unsigned        plan_upper = 0;

   function automatic stack_result_t predict_stack_op(input logic kind, input logic sel,
                                                      input logic [WORD_W-1:0] word);
      stack_result_t res;
      res.status = STATUS_DONE;
      res.word   = '0;
      if (kind == REQ_PUSH) begin
         // both stacks draw on the same free space
         if (lower_fill + upper_fill >= DEPTH) begin
            res.status = STATUS_FULL;
         end else if (sel == SEL_LOWER) begin
            stack_words[lower_fill] = word;
            lower_fill++;
         end else begin
            upper_fill++;
            stack_words[DEPTH - upper_fill] = word;
         end
      end else if (sel == SEL_LOWER) begin
         if (lower_fill == 0) begin
            res.status = STATUS_EMPTY;
         end else begin
            lower_fill--;
            res.word = stack_words[lower_fill];
         end
      end else begin
         if (upper_fill == 0) begin
            res.status = STATUS_EMPTY;
         end else begin
            res.word = stack_words[DEPTH - upper_fill];
            upper_fill--;
         end
      end
      return res;
   endfunction

   // ---------------------------------------------------------------------------
   // Monitor: everything sampled at the rising edge, before the DUT's own
   // updates land. A result beat is checked against the oldest prediction;
   // an accepted request beat is run through the model.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      stack_result_t want;
      typed_result_t fixed_exp;
      if (reset === 1'b0) begin
         if (rsp_strobe !== 1'b0) begin
            if (pending_results.size() == 0) begin
               $error("rsp_strobe: result beat with no request outstanding");
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_status !== want.status) begin
                  $error("rsp_status: expected %0d, got %0d", want.status, rsp_status);
                  error_count++;
               end
               if (rsp_pop_value !== want.word) begin
                  $error("rsp_pop_value: expected %h, got %h", want.word, rsp_pop_value);
                  error_count++;
               end
            end
         end
         if (start === 1'b1 && busy === 1'b0) begin
            fixed_exp = typed_results.pop_front();
            // model state always advances; a typed-in value overrides it
            want = predict_stack_op(req_type, req_stack_sel, req_push_value);
            if (fixed_exp.fixed) begin
               want.status = fixed_exp.status;
               want.word   = fixed_exp.pop_word;
            end
            pending_results.push_back(want);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Driver: one request beat, with a random gap in front of it.
   // Sender idles 34% for the first 150 beats, 52% for the next 150, then
   // runs back to back.
   // ---------------------------------------------------------------------------
   task automatic send_beat(input logic kind, input logic sel,
                            input logic [WORD_W-1:0] word, input typed_result_t fixed_exp);
      int idle_pct;
      idle_pct = (beats_sent < 150) ? 34 : ((beats_sent < 300) ? 52 : 0);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_type       <= kind;
      req_stack_sel  <= sel;
      req_push_value <= word;
      typed_results.push_back(fixed_exp);
      // track fill levels for steering only
      if (kind == REQ_PUSH) begin
         if (plan_lower + plan_upper < DEPTH) begin
            if (sel == SEL_LOWER) plan_lower++;
            else plan_upper++;
         end
      end else if (sel == SEL_LOWER) begin
         if (plan_lower > 0) plan_lower--;
      end else begin
         if (plan_upper > 0) plan_upper--;
      end
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      beats_sent++;
   endtask

   // ---------------------------------------------------------------------------
   // Directed beats: empty pops on both sides, extreme words, interleaved
   // push/pop on each stack, pop with a junk push word. Memory-full refusals
   // come from the fill episodes of the random part.
   // ---------------------------------------------------------------------------
   directed_beat_t directed_plan [21] = '{
      '{REQ_POP,  SEL_LOWER, 32'hffff_ffff, 1'b1, STATUS_EMPTY, 32'h0000_0000},
      '{REQ_POP,  SEL_UPPER, 32'h1234_5678, 1'b1, STATUS_EMPTY, 32'h0000_0000},
      '{REQ_PUSH, SEL_LOWER, 32'h7fff_ffff, 1'b1, STATUS_DONE,  32'h0000_0000},
      '{REQ_PUSH, SEL_UPPER, 32'h8000_0000, 1'b1, STATUS_DONE,  32'h0000_0000},
      '{REQ_POP,  SEL_UPPER, 32'h0000_0000, 1'b1, STATUS_DONE,  32'h8000_0000},
      '{REQ_POP,  SEL_UPPER, 32'h0000_0000, 1'b1, STATUS_EMPTY, 32'h0000_0000},
      '{REQ_POP,  SEL_LOWER, 32'h0000_0000, 1'b1, STATUS_DONE,  32'h7fff_ffff},
      '{REQ_POP,  SEL_LOWER, 32'h0000_0000, 1'b1, STATUS_EMPTY, 32'h0000_0000},
      '{REQ_PUSH, SEL_LOWER, 32'hffff_ffff, 1'b1, STATUS_DONE,  32'h0000_0000},
      '{REQ_PUSH, SEL_LOWER, 32'h0000_0000, 1'b1, STATUS_DONE,  32'h0000_0000},
      '{REQ_PUSH, SEL_UPPER, 32'h0000_0001, 1'b1, STATUS_DONE,  32'h0000_0000},
      '{REQ_PUSH, SEL_UPPER, 32'haaaa_aaaa, 1'b0, STATUS_DONE,  32'h0000_0000},
      '{REQ_POP,  SEL_LOWER, 32'hdead_beef, 1'b1, STATUS_DONE,  32'h0000_0000},
      '{REQ_POP,  SEL_UPPER, 32'h0000_0000, 1'b1, STATUS_DONE,  32'haaaa_aaaa},
      '{REQ_PUSH, SEL_UPPER, 32'h5555_5555, 1'b0, STATUS_DONE,  32'h0000_0000},
      '{REQ_POP,  SEL_UPPER, 32'h0000_0000, 1'b0, STATUS_DONE,  32'h0000_0000},
      '{REQ_PUSH, SEL_LOWER, 32'h3c5a_0f96, 1'b0, STATUS_DONE,  32'h0000_0000},
      '{REQ_POP,  SEL_LOWER, 32'h0000_0000, 1'b0, STATUS_DONE,  32'h0000_0000},
      '{REQ_POP,  SEL_LOWER, 32'h0000_0000, 1'b1, STATUS_DONE,  32'hffff_ffff},
      '{REQ_POP,  SEL_UPPER, 32'h0000_0000, 1'b1, STATUS_DONE,  32'h0000_0001},
      '{REQ_POP,  SEL_UPPER, 32'h0000_0000, 1'b1, STATUS_EMPTY, 32'h0000_0000}
   };

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin
      logic               kind;
      logic               sel;
      logic [WORD_W-1:0]  word;
      bit                 filling;
      int                 upper_pct;
      int                 steer_pct;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         send_beat(directed_plan[i].kind, directed_plan[i].sel, directed_plan[i].push_word,
                   typed_result_t'{directed_plan[i].fixed, directed_plan[i].status,
                                   directed_plan[i].pop_word});
      end

      // Random part: alternating fill and drain episodes. A fill episode
      // pushes 85% of the time and lingers at full for a while, so both
      // stacks see full refusals; a drain episode pops 85% of the time until
      // both stacks are empty. Each episode skews toward one stack or neither.
      filling   = 1'b1;
      upper_pct = 50;
      repeat (RANDOM_BEATS) begin
         if (filling && plan_lower + plan_upper == DEPTH && $urandom_range(5) == 0) begin
            filling = 1'b0;
         end else if (!filling && plan_lower + plan_upper == 0 && $urandom_range(3) == 0) begin
            filling = 1'b1;
            case ($urandom_range(2))
               0: begin
                  upper_pct = 10;
               end
               1: begin
                  upper_pct = 50;
               end
               default: begin
                  upper_pct = 90;
               end
            endcase
         end

         if (filling) kind = ($urandom_range(99) < 85) ? REQ_PUSH : REQ_POP;
         else kind = ($urandom_range(99) < 85) ? REQ_POP : REQ_PUSH;

         // while draining, lean on whichever stack still holds words
         steer_pct = upper_pct;
         if (!filling && plan_lower == 0) steer_pct = 85;
         else if (!filling && plan_upper == 0) steer_pct = 15;
         sel = ($urandom_range(99) < steer_pct) ? SEL_UPPER : SEL_LOWER;

         case ($urandom_range(7))
            0: begin
               word = 32'h8000_0000;
            end
            1: begin
               word = 32'h7fff_ffff;
            end
            2: begin
               word = '0;
            end
            3: begin
               word = '1;
            end
            default: begin
               word = $urandom;
            end
         endcase

         send_beat(kind, sel, word, '0);
      end

      start <= 1'b0;
      // watchdog bounds this wait
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && pending_results.size() == 0) begin
         $display("shared_double_ended_stack_unit regression: pass");
      end else begin
         $display("shared_double_ended_stack_unit regression: fail");
      end
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Watchdog: ends the run after too many cycles with no beat moving
   // ---------------------------------------------------------------------------
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (rsp_strobe === 1'b1 || (start === 1'b1 && busy === 1'b0)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("shared_double_ended_stack_unit regression: fail");
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl
rtl/sdes_pkg.sv
rtl/sdes_mem.sv
rtl/sdes_ctrl.sv
rtl/shared_double_ended_stack_unit.sv
tb/testbench.sv
